>>> sv/v3fx_pkg.sv
// v3fx_pkg: shared opcodes and default widths for the vector fixed point unit.
// No dependencies; used by every module of the block.
package v3fx_pkg;

	localparam int COMP_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int OP_WIDTH       = 3;

	// operation codes carried on the op field
	typedef enum logic [OP_WIDTH-1:0] {
		OP_DOT   = 3'd0,
		OP_CROSS = 3'd1,
		OP_NORM  = 3'd2,
		OP_FLOOR = 3'd3,
		OP_CEIL  = 3'd4
	} op_t;

endpackage

>>> sv/v3fx_lane.sv
// v3fx_lane: one component lane: products, square of |a|, floor/ceil, cross term.
// Depends on v3fx_pkg for default widths.
module v3fx_lane #(
	parameter int COMP_WIDTH = v3fx_pkg::COMP_WIDTH_DEF,
	parameter int FRAC_BITS  = v3fx_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           en,
	input  logic                           ceil_sel,
	input  logic signed [COMP_WIDTH-1:0]   ai,
	input  logic signed [COMP_WIDTH-1:0]   bi,
	input  logic signed [COMP_WIDTH-1:0]   aj,
	input  logic signed [COMP_WIDTH-1:0]   bk,
	input  logic signed [COMP_WIDTH-1:0]   ak,
	input  logic signed [COMP_WIDTH-1:0]   bj,
	output logic signed [2*COMP_WIDTH-1:0] pd_s2,
	output logic [2*COMP_WIDTH-1:0]        sq_s2,
	output logic [COMP_WIDTH-1:0]          cr_s3,
	output logic                           cr_ov_s3,
	output logic [COMP_WIDTH-1:0]          fc_s3,
	output logic                           fc_ov_s3,
	output logic [COMP_WIDTH-1:0]          mag_s3,
	output logic                           sgn_s3
);

	localparam int W  = COMP_WIDTH;
	localparam int EW = ((W > FRAC_BITS) ? W : FRAC_BITS + 1) + 2;
	localparam logic [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MAX_NEG = {1'b1, {(W-1){1'b0}}};

	logic signed [2*W-1:0] px_s2, py_s2;
	logic [W-1:0]          fc_s2, mag_s2;
	logic                  fc_ov_s2, sgn_s2;

	logic [W-1:0]    mag;
	logic [EW-1:0]   fmask, fv;
	logic [EW-W:0]   fhi;
	logic            fov;
	logic [W-1:0]    fres;

	// magnitude of a, exact even for the most negative value
	assign mag = ai[W-1] ? (~ai + 1'b1) : ai;

	// floor clears fraction bits; ceil adds the fraction mask first
	assign fmask = (EW'(1) << FRAC_BITS) - EW'(1);
	always_comb begin
		fv = {{(EW-W){ai[W-1]}}, ai};
		if (ceil_sel) begin
			fv = fv + fmask;
		end
		fv   = fv & ~fmask;
		fhi  = fv[EW-1:W-1];
		fov  = !((&fhi) || !(|fhi));
		fres = fov ? (fv[EW-1] ? MAX_NEG : MAX_POS) : fv[W-1:0];
	end

	// stage 2: products, plus the floor/ceil result, |a| and the sign of a
	always_ff @(posedge clk) begin
		if (en) begin
			pd_s2    <= (2*W)'(ai) * (2*W)'(bi);
			px_s2    <= (2*W)'(aj) * (2*W)'(bk);
			py_s2    <= (2*W)'(ak) * (2*W)'(bj);
			sq_s2    <= (2*W)'(mag) * (2*W)'(mag);
			fc_s2    <= fres;
			fc_ov_s2 <= fov;
			mag_s2   <= mag;
			sgn_s2   <= ai[W-1];
		end
	end

	logic signed [2*W:0] cd, csh;
	logic [W+1:0]        chi;
	logic                cov;

	// cross term: difference, arithmetic shift, saturate
	always_comb begin
		cd  = {px_s2[2*W-1], px_s2} - {py_s2[2*W-1], py_s2};
		csh = cd >>> FRAC_BITS;
		chi = csh[2*W:W-1];
		cov = !((&chi) || !(|chi));
	end

	// stage 3
	always_ff @(posedge clk) begin
		if (en) begin
			cr_s3    <= cov ? (csh[2*W] ? MAX_NEG : MAX_POS) : csh[W-1:0];
			cr_ov_s3 <= cov;
			fc_s3    <= fc_s2;
			fc_ov_s3 <= fc_ov_s2;
			mag_s3   <= mag_s2;
			sgn_s3   <= sgn_s2;
		end
	end

endmodule

>>> sv/v3fx_isqrt.sv
// v3fx_isqrt: pipelined integer square root, one result bit per stage.
// Depends on v3fx_pkg for default widths; carries a sideband beside the radicand.
module v3fx_isqrt #(
	parameter int COMP_WIDTH = v3fx_pkg::COMP_WIDTH_DEF,
	parameter int SB_WIDTH   = 1
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic [2*COMP_WIDTH-1:0] rad,
	input  logic [SB_WIDTH-1:0]     sb_in,
	output logic [COMP_WIDTH-1:0]   root,
	output logic [SB_WIDTH-1:0]     sb_out
);

	localparam int W  = COMP_WIDTH;
	localparam int RW = W + 3;

	logic [2*W-1:0]      rad_q  [W];
	logic [RW-1:0]       rem_q  [W];
	logic [W-1:0]        root_q [W];
	logic [SB_WIDTH-1:0] sb_q   [W];

	for (genvar k = 0; k < W; k++) begin : g_stg
		logic [2*W-1:0]      rad_i;
		logic [RW-1:0]       rem_i, rem_t, trial;
		logic [W-1:0]        root_i;
		logic [SB_WIDTH-1:0] sb_i;

		if (k == 0) begin : g_first
			assign rad_i  = rad;
			assign rem_i  = '0;
			assign root_i = '0;
			assign sb_i   = sb_in;
		end else begin : g_next
			assign rad_i  = rad_q[k-1];
			assign rem_i  = rem_q[k-1];
			assign root_i = root_q[k-1];
			assign sb_i   = sb_q[k-1];
		end

		// bring down two radicand bits, try root*4+1
		assign rem_t = {rem_i[RW-3:0], rad_i[2*W-1 -: 2]};
		assign trial = {1'b0, root_i, 2'b01};

		always_ff @(posedge clk) begin
			if (en) begin
				rad_q[k] <= {rad_i[2*W-3:0], 2'b00};
				sb_q[k]  <= sb_i;
				if (rem_t >= trial) begin
					rem_q[k]  <= rem_t - trial;
					root_q[k] <= {root_i[W-2:0], 1'b1};
				end else begin
					rem_q[k]  <= rem_t;
					root_q[k] <= {root_i[W-2:0], 1'b0};
				end
			end
		end
	end

	assign root   = root_q[W-1];
	assign sb_out = sb_q[W-1];

endmodule

>>> sv/v3fx_div.sv
// v3fx_div: pipelined restoring divider, (mag << FRAC_BITS) / den, one bit per stage.
// Depends on v3fx_pkg for default widths; carries a sideband beside the operands.
module v3fx_div #(
	parameter int COMP_WIDTH = v3fx_pkg::COMP_WIDTH_DEF,
	parameter int FRAC_BITS  = v3fx_pkg::FRAC_BITS_DEF,
	parameter int SB_WIDTH   = 1
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic [COMP_WIDTH-1:0]             mag,
	input  logic [COMP_WIDTH-1:0]             den,
	input  logic [SB_WIDTH-1:0]               sb_in,
	output logic [COMP_WIDTH+FRAC_BITS-1:0]   quo,
	output logic [SB_WIDTH-1:0]               sb_out
);

	localparam int W  = COMP_WIDTH;
	localparam int NW = COMP_WIDTH + FRAC_BITS;

	logic [NW-1:0]       num_q [NW];
	logic [NW-1:0]       quo_q [NW];
	logic [W-1:0]        rem_q [NW];
	logic [W-1:0]        den_q [NW];
	logic [SB_WIDTH-1:0] sb_q  [NW];

	for (genvar k = 0; k < NW; k++) begin : g_stg
		logic [NW-1:0]       num_i, quo_i;
		logic [W-1:0]        rem_i, den_i;
		logic [SB_WIDTH-1:0] sb_i;
		logic [W:0]          rem_t, rem_d;
		logic                ge;

		if (k == 0) begin : g_first
			assign num_i = NW'(mag) << FRAC_BITS;
			assign quo_i = '0;
			assign rem_i = '0;
			assign den_i = den;
			assign sb_i  = sb_in;
		end else begin : g_next
			assign num_i = num_q[k-1];
			assign quo_i = quo_q[k-1];
			assign rem_i = rem_q[k-1];
			assign den_i = den_q[k-1];
			assign sb_i  = sb_q[k-1];
		end

		// shift in the next numerator bit and try a subtract
		assign rem_t = {rem_i, num_i[NW-1]};
		assign rem_d = rem_t - {1'b0, den_i};
		assign ge    = (rem_t >= {1'b0, den_i});

		always_ff @(posedge clk) begin
			if (en) begin
				num_q[k] <= {num_i[NW-2:0], 1'b0};
				quo_q[k] <= {quo_i[NW-2:0], ge};
				rem_q[k] <= ge ? rem_d[W-1:0] : rem_t[W-1:0];
				den_q[k] <= den_i;
				sb_q[k]  <= sb_i;
			end
		end
	end

	assign quo    = quo_q[NW-1];
	assign sb_out = sb_q[NW-1];

endmodule

>>> sv/vector3_fixed_point_unit.sv
// vector3_fixed_point_unit: dot, cross, normalize, floor, ceil on Q-format 3-vectors.
// The square root takes COMP_WIDTH stages and each lane divider
// COMP_WIDTH+FRAC_BITS stages. Throughput one beat per cycle unless the output stalls;
// every op runs the full pipeline so results stay in order.
// arst_n clears only the valid bits; payload registers are not reset.
// Depends on v3fx_pkg, v3fx_lane, v3fx_isqrt, v3fx_div.
module vector3_fixed_point_unit #(
	parameter int COMP_WIDTH = v3fx_pkg::COMP_WIDTH_DEF,
	parameter int FRAC_BITS  = v3fx_pkg::FRAC_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [v3fx_pkg::OP_WIDTH-1:0]        op,
	input  logic signed [COMP_WIDTH-1:0]         ax,
	input  logic signed [COMP_WIDTH-1:0]         ay,
	input  logic signed [COMP_WIDTH-1:0]         az,
	input  logic signed [COMP_WIDTH-1:0]         bx,
	input  logic signed [COMP_WIDTH-1:0]         by,
	input  logic signed [COMP_WIDTH-1:0]         bz,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [COMP_WIDTH-1:0]         rx,
	output logic signed [COMP_WIDTH-1:0]         ry,
	output logic signed [COMP_WIDTH-1:0]         rz,
	output logic signed [COMP_WIDTH-1:0]         scalar,
	output logic                                 zero_length,
	output logic                                 overflow
);

	localparam int W     = COMP_WIDTH;
	localparam int OW    = v3fx_pkg::OP_WIDTH;
	localparam int NW    = COMP_WIDTH + FRAC_BITS;
	localparam int LAT   = 2 * COMP_WIDTH + FRAC_BITS + 4;
	localparam int SQ_SB = OW + 2 + 7 * COMP_WIDTH + 3;
	localparam int DV_SB = OW + 2 + 4 * COMP_WIDTH + 1;
	localparam logic [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MAX_NEG = {1'b1, {(W-1){1'b0}}};

	logic           adv;
	logic [LAT-1:0] vld_q;

	// whole pipeline moves unless a finished beat sits stalled at the output
	assign adv       = !out_valid || !out_stall;
	assign in_stall  = !adv;
	assign out_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	// stage 1: input register
	logic [OW-1:0]         op_s1;
	logic signed [W-1:0]   a_s1 [3];
	logic signed [W-1:0]   b_s1 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1   <= op;
			a_s1[0] <= ax;
			a_s1[1] <= ay;
			a_s1[2] <= az;
			b_s1[0] <= bx;
			b_s1[1] <= by;
			b_s1[2] <= bz;
		end
	end

	// stages 2 and 3: component lanes
	logic signed [2*W-1:0] pd_s2 [3];
	logic [2*W-1:0]        sq_s2 [3];
	logic [W-1:0]          cr_s3 [3], fc_s3 [3], mag_s3 [3];
	logic                  cr_ov_s3 [3], fc_ov_s3 [3], sgn_s3 [3];
	logic                  ceil_sel;

	assign ceil_sel = (op_s1 == v3fx_pkg::OP_CEIL);

	for (genvar i = 0; i < 3; i++) begin : g_lane
		localparam int J = (i + 1) % 3;
		localparam int K = (i + 2) % 3;
		v3fx_lane #(
			.COMP_WIDTH(COMP_WIDTH),
			.FRAC_BITS (FRAC_BITS)
		) u_lane (
			.clk     (clk),
			.en      (adv),
			.ceil_sel(ceil_sel),
			.ai      (a_s1[i]),
			.bi      (b_s1[i]),
			.aj      (a_s1[J]),
			.bk      (b_s1[K]),
			.ak      (a_s1[K]),
			.bj      (b_s1[J]),
			.pd_s2   (pd_s2[i]),
			.sq_s2   (sq_s2[i]),
			.cr_s3   (cr_s3[i]),
			.cr_ov_s3(cr_ov_s3[i]),
			.fc_s3   (fc_s3[i]),
			.fc_ov_s3(fc_ov_s3[i]),
			.mag_s3  (mag_s3[i]),
			.sgn_s3  (sgn_s3[i])
		);
	end

	logic [OW-1:0] op_s2, op_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			op_s2 <= op_s1;
			op_s3 <= op_s2;
		end
	end

	// stage 3 merge: dot sum and squared length
	logic signed [2*W+1:0] dsum, dsh;
	logic [W+2:0]          dhi;
	logic                  dov;
	logic [2*W+1:0]        ssum;
	logic [W-1:0]          sc_s3;
	logic                  dov_s3;
	logic [2*W-1:0]        s_s3;

	always_comb begin
		dsum = (2*W+2)'(pd_s2[0]) + (2*W+2)'(pd_s2[1]) + (2*W+2)'(pd_s2[2]);
		dsh  = dsum >>> FRAC_BITS;
		dhi  = dsh[2*W+1:W-1];
		dov  = !((&dhi) || !(|dhi));
		ssum = (2*W+2)'(sq_s2[0]) + (2*W+2)'(sq_s2[1]) + (2*W+2)'(sq_s2[2]);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sc_s3  <= dov ? (dsh[2*W+1] ? MAX_NEG : MAX_POS) : dsh[W-1:0];
			dov_s3 <= dov;
			s_s3   <= ssum[2*W-1:0];
		end
	end

	// early results for everything but normalize
	logic [W-1:0] er [3];
	logic [W-1:0] esc;
	logic         eov, zl;

	always_comb begin
		er[0] = '0;
		er[1] = '0;
		er[2] = '0;
		esc   = '0;
		eov   = 1'b0;
		zl    = 1'b0;
		unique case (op_s3)
			v3fx_pkg::OP_DOT: begin
				esc = sc_s3;
				eov = dov_s3;
			end
			v3fx_pkg::OP_CROSS: begin
				er[0] = cr_s3[0];
				er[1] = cr_s3[1];
				er[2] = cr_s3[2];
				eov   = cr_ov_s3[0] | cr_ov_s3[1] | cr_ov_s3[2];
			end
			v3fx_pkg::OP_NORM: begin
				zl = (s_s3 == '0);
			end
			v3fx_pkg::OP_FLOOR, v3fx_pkg::OP_CEIL: begin
				er[0] = fc_s3[0];
				er[1] = fc_s3[1];
				er[2] = fc_s3[2];
				eov   = fc_ov_s3[0] | fc_ov_s3[1] | fc_ov_s3[2];
			end
			default: begin
			end
		endcase
	end

	// square root of |a|^2, everything else rides along
	logic [SQ_SB-1:0] sq_sb_in, sq_sb_out;
	logic [W-1:0]     len;

	assign sq_sb_in = {op_s3, zl, eov, esc, er[0], er[1], er[2],
		mag_s3[0], mag_s3[1], mag_s3[2], sgn_s3[0], sgn_s3[1], sgn_s3[2]};

	v3fx_isqrt #(
		.COMP_WIDTH(COMP_WIDTH),
		.SB_WIDTH  (SQ_SB)
	) u_isqrt (
		.clk   (clk),
		.en    (adv),
		.rad   (s_s3),
		.sb_in (sq_sb_in),
		.root  (len),
		.sb_out(sq_sb_out)
	);

	logic [OW-1:0] q_op;
	logic          q_zl, q_eov;
	logic [W-1:0]  q_esc, q_er0, q_er1, q_er2, q_m0, q_m1, q_m2;
	logic          q_s0, q_s1, q_s2;

	assign {q_op, q_zl, q_eov, q_esc, q_er0, q_er1, q_er2,
		q_m0, q_m1, q_m2, q_s0, q_s1, q_s2} = sq_sb_out;

	// one divider per lane; lane 0 carries the item's other results
	logic [DV_SB-1:0] dv_sb_out;
	logic [NW-1:0]    quo [3];
	logic             dsgn [3];
	logic [OW-1:0]    d_op;
	logic             d_zl, d_eov;
	logic [W-1:0]     d_esc, d_er0, d_er1, d_er2;

	v3fx_div #(
		.COMP_WIDTH(COMP_WIDTH),
		.FRAC_BITS (FRAC_BITS),
		.SB_WIDTH  (DV_SB)
	) u_div0 (
		.clk   (clk),
		.en    (adv),
		.mag   (q_m0),
		.den   (len),
		.sb_in ({q_op, q_zl, q_eov, q_esc, q_er0, q_er1, q_er2, q_s0}),
		.quo   (quo[0]),
		.sb_out(dv_sb_out)
	);

	v3fx_div #(
		.COMP_WIDTH(COMP_WIDTH),
		.FRAC_BITS (FRAC_BITS),
		.SB_WIDTH  (1)
	) u_div1 (
		.clk   (clk),
		.en    (adv),
		.mag   (q_m1),
		.den   (len),
		.sb_in (q_s1),
		.quo   (quo[1]),
		.sb_out(dsgn[1])
	);

	v3fx_div #(
		.COMP_WIDTH(COMP_WIDTH),
		.FRAC_BITS (FRAC_BITS),
		.SB_WIDTH  (1)
	) u_div2 (
		.clk   (clk),
		.en    (adv),
		.mag   (q_m2),
		.den   (len),
		.sb_in (q_s2),
		.quo   (quo[2]),
		.sb_out(dsgn[2])
	);

	assign {d_op, d_zl, d_eov, d_esc, d_er0, d_er1, d_er2, dsgn[0]} = dv_sb_out;

	// apply sign and saturate each normalized component
	logic signed [NW:0] qs [3];
	logic [NW-W+1:0]    qhi [3];
	logic               nov [3];
	logic [W-1:0]       nr [3];

	for (genvar i = 0; i < 3; i++) begin : g_fin
		always_comb begin
			qs[i]  = dsgn[i] ? -$signed({1'b0, quo[i]}) : $signed({1'b0, quo[i]});
			qhi[i] = qs[i][NW:W-1];
			nov[i] = !((&qhi[i]) || !(|qhi[i]));
			nr[i]  = nov[i] ? (qs[i][NW] ? MAX_NEG : MAX_POS) : qs[i][W-1:0];
		end
	end

	// output register
	logic [W-1:0] rx_q, ry_q, rz_q, sc_q;
	logic         zl_q, ov_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			sc_q <= d_esc;
			zl_q <= d_zl;
			if (d_op == v3fx_pkg::OP_NORM && !d_zl) begin
				rx_q <= nr[0];
				ry_q <= nr[1];
				rz_q <= nr[2];
				ov_q <= nov[0] | nov[1] | nov[2];
			end else begin
				rx_q <= d_er0;
				ry_q <= d_er1;
				rz_q <= d_er2;
				ov_q <= d_eov;
			end
		end
	end

	assign rx          = rx_q;
	assign ry          = ry_q;
	assign rz          = rz_q;
	assign scalar      = sc_q;
	assign zero_length = zl_q;
	assign overflow    = ov_q;

endmodule

>>> tb/v3fx_checker.sv
// v3fx_checker: watches both channels of the vector unit, predicts each result and compares.
// Depends on v3fx_pkg for the opcodes.
module v3fx_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [2:0]         op,
	input  logic signed [31:0] ax,
	input  logic signed [31:0] ay,
	input  logic signed [31:0] az,
	input  logic signed [31:0] bx,
	input  logic signed [31:0] by,
	input  logic signed [31:0] bz,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [31:0] rx,
	input  logic signed [31:0] ry,
	input  logic signed [31:0] rz,
	input  logic signed [31:0] scalar,
	input  logic               zero_length,
	input  logic               overflow,
	output int                 errors,
	output int                 pending,
	output int                 results_seen
);

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic signed [31:0] s;
		logic               zl;
		logic               ov;
	} vec_result_t;

	vec_result_t expected_q[$];

	localparam logic signed [127:0] QMAX = 128'sd2147483647;
	localparam logic signed [127:0] QMIN = -128'sd2147483648;

	// clamp a wide value to Q16.16 range
	function automatic logic signed [31:0] clamp32(input logic signed [127:0] v,
			inout logic ov);
		if (v > QMAX) begin
			ov = 1'b1;
			return 32'sh7fffffff;
		end
		if (v < QMIN) begin
			ov = 1'b1;
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	// integer square root, floor
	function automatic logic [63:0] root_floor(input logic [127:0] s);
		logic [63:0]  r;
		logic [63:0]  t;
		logic [127:0] tt;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			t = r | (64'd1 << b);
			tt = t * t;
			if (tt <= s) r = t;
		end
		return r;
	endfunction

	function automatic vec_result_t vec_compute(input logic [2:0] code,
			input logic signed [31:0] a[3], input logic signed [31:0] b[3]);
		vec_result_t       res;
		logic signed [127:0] acc;
		logic [127:0]      sq;
		logic [127:0]      num;
		logic [127:0]      quo;
		logic [63:0]       len;
		logic signed [31:0] comp[3];
		logic              ov;
		res = '0;
		ov = 1'b0;
		comp = '{0, 0, 0};
		case (code)
			v3fx_pkg::OP_DOT: begin
				acc = 128'(a[0]) * 128'(b[0]) + 128'(a[1]) * 128'(b[1])
					+ 128'(a[2]) * 128'(b[2]);
				res.s = clamp32(acc >>> 16, ov);
			end
			v3fx_pkg::OP_CROSS: begin
				for (int i = 0; i < 3; i++) begin
					acc = 128'(a[(i+1)%3]) * 128'(b[(i+2)%3])
						- 128'(a[(i+2)%3]) * 128'(b[(i+1)%3]);
					comp[i] = clamp32(acc >>> 16, ov);
				end
			end
			v3fx_pkg::OP_NORM: begin
				sq = 0;
				for (int i = 0; i < 3; i++) sq += 128'(128'(a[i]) * 128'(a[i]));
				if (sq == 0) begin
					res.zl = 1'b1;
				end else begin
					len = root_floor(sq);
					for (int i = 0; i < 3; i++) begin
						num = a[i] < 0 ? 128'(-128'(a[i])) : 128'(a[i]);
						quo = (num << 16) / len;
						acc = a[i] < 0 ? -$signed(quo) : $signed(quo);
						comp[i] = clamp32(acc, ov);
					end
				end
			end
			v3fx_pkg::OP_FLOOR, v3fx_pkg::OP_CEIL: begin
				for (int i = 0; i < 3; i++) begin
					acc = 128'(a[i]);
					if (code == v3fx_pkg::OP_CEIL) acc += 128'sh0ffff;
					acc[15:0] = '0;
					comp[i] = clamp32(acc, ov);
				end
			end
			default: ;
		endcase
		res.x = comp[0];
		res.y = comp[1];
		res.z = comp[2];
		res.ov = ov;
		return res;
	endfunction

	assign pending = expected_q.size();

	// predict on input beats, compare on output beats
	always @(posedge clk or negedge arst_n) begin
		vec_result_t got;
		vec_result_t want;
		if (!arst_n) begin
			errors <= 0;
			results_seen <= 0;
			expected_q.delete();
		end else begin
			if (in_valid && !in_stall)
				expected_q.push_back(vec_compute(op, '{ax, ay, az}, '{bx, by, bz}));
			if (out_valid && !out_stall) begin
				got = '{rx, ry, rz, scalar, zero_length, overflow};
				results_seen <= results_seen + 1;
				if (expected_q.size() == 0) begin
					$display("%0t: result beat with nothing expected: %p", $time, got);
					errors <= errors + 1;
				end else begin
					want = expected_q.pop_front();
					if (got !== want) begin
						$display("%0t: mismatch expected %p actual %p", $time, want, got);
						errors <= errors + 1;
					end
				end
			end
		end
	end
endmodule

>>> tb/tb.sv
// tb: stimulus and verdict for vector3_fixed_point_unit.
// Depends on v3fx_pkg, the block and v3fx_checker.
module tb;

	localparam int LATENCY = 84;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [2:0]         op;
	logic signed [31:0] ax, ay, az, bx, by, bz;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] rx, ry, rz, scalar;
	logic               zero_length, overflow;
	int                 errors, pending, results_seen;
	bit                 quiet;
	int                 items_sent;

	vector3_fixed_point_unit dut (.*);

	v3fx_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("tb NOT OK");
		$finish;
	end

	// receiver stall bursts
	initial begin
		int n;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 9) == 0) begin
				n = $urandom_range(1, 19);
				repeat (n) begin
					out_stall <= 1'b1;
					@(negedge clk);
				end
				out_stall <= 1'b0;
			end
		end
	end

	function automatic logic signed [31:0] rand_comp();
		case ($urandom_range(0, 5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return $signed($urandom_range(0, 32'h7ffff)) - 32'sh40000;
			3: return 32'(int'($urandom_range(0, 20)) - 10) <<< 16;
			4: return 0;
			default: return $urandom();
		endcase
	endfunction

	// drive one beat; hold until accepted
	task automatic send_vec(input logic [2:0] code, input logic signed [31:0] v[6]);
		if (!quiet && $urandom_range(0, 9) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		in_valid <= 1'b1;
		op <= code;
		{ax, ay, az, bx, by, bz} <= {v[0], v[1], v[2], v[3], v[4], v[5]};
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic send_random(input int weird);
		logic signed [31:0] v[6];
		logic [2:0]         code;
		foreach (v[i]) v[i] = rand_comp();
		code = weird ? 3'($urandom_range(0, 7)) : 3'($urandom_range(0, 4));
		if (code == v3fx_pkg::OP_NORM && $urandom_range(0, 9) == 0) begin
			v[0] = 0;
			v[1] = 0;
			v[2] = 0;
		end
		send_vec(code, v);
	endtask

	initial begin
		logic signed [31:0] mx, mn;
		mx = 32'sh7fffffff;
		mn = 32'sh80000000;
		quiet = 1'b0;
		items_sent = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = v3fx_pkg::OP_DOT;
		{ax, ay, az, bx, by, bz} = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: extremes, every op, zero-length normalize, ceil saturation, unused codes
		send_vec(v3fx_pkg::OP_DOT, '{mx, mx, mx, mx, mx, mx});
		send_vec(v3fx_pkg::OP_DOT, '{mn, mn, mn, mn, mn, mn});
		send_vec(v3fx_pkg::OP_DOT, '{mx, mn, 1, mn, mx, -1});
		send_vec(v3fx_pkg::OP_CROSS, '{mx, mn, mx, mn, mx, mn});
		send_vec(v3fx_pkg::OP_CROSS, '{32'sh10000, 0, 0, 0, 32'sh10000, 0});
		send_vec(v3fx_pkg::OP_NORM, '{0, 0, 0, 5, 5, 5});
		send_vec(v3fx_pkg::OP_NORM, '{mn, mn, mn, 0, 0, 0});
		send_vec(v3fx_pkg::OP_NORM, '{mx, 0, 0, 0, 0, 0});
		send_vec(v3fx_pkg::OP_NORM, '{1, 0, 0, 0, 0, 0});
		send_vec(v3fx_pkg::OP_NORM, '{-1, 1, -1, 0, 0, 0});
		send_vec(v3fx_pkg::OP_FLOOR, '{mx, mn, -32'sh18000, 0, 0, 0});
		send_vec(v3fx_pkg::OP_FLOOR, '{-1, 1, 32'sh10000, 0, 0, 0});
		send_vec(v3fx_pkg::OP_CEIL, '{mx, mn, -32'sh18000, 0, 0, 0});
		send_vec(v3fx_pkg::OP_CEIL, '{32'sh7fff0001, 32'sh7fff0000, -1, 0, 0, 0});
		send_vec(3'd5, '{mx, mx, mx, mx, mx, mx});
		send_vec(3'd6, '{1, 2, 3, 4, 5, 6});
		send_vec(3'd7, '{mn, mn, mn, mn, mn, mn});

		// hold off until the pipeline has drained
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);

		for (int k = 0; k < 1400; k++) begin
			if (k == 1200) quiet = 1'b1;
			send_random($urandom_range(0, 19) == 0);
		end
		in_valid <= 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (LATENCY + 10) @(negedge clk);
		$display("sent %0d beats over all five ops plus unused codes; %0d results checked",
			items_sent, results_seen);
		if (errors == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end
endmodule
